// ===== rtl/cnoise_pkg.sv =====
// ----------------------------------------------------------------------------
// cnoise_pkg
// Shared widths, register codes and the candidate record passed between the
// distance cells of the cellular noise shader.
// ----------------------------------------------------------------------------
`default_nettype none

package cnoise_pkg;

   // Default sizing of the point store and coordinate format.
   localparam int MAX_POINTS_DEF     = 128;
   localparam int COORD_INT_BITS_DEF = 12;

   // Field widths of requests and results.
   localparam int FRAC_W   = 4;
   localparam int PIX_W    = 12;
   localparam int COORD_W  = PIX_W + FRAC_W;
   localparam int SLOT_W   = 7;
   localparam int WEIGHT_W = 16;
   localparam int NUM_W    = 8;
   localparam int HEIGHT_W = 22;

   // Arithmetic widths. A squared distance needs 33 bits; the root unit
   // wants an even width.
   localparam int SQ_W   = 34;
   localparam int ROOT_W = SQ_W / 2;
   localparam int PROD_W = WEIGHT_W + ROOT_W + 1;
   localparam int SUM_W  = PROD_W + 1;

   // Number of nearest distances kept, one cell each.
   localparam int NEAREST_KEPT = 2;
   localparam int MIN_POINTS   = 2;

   // Q.16 to Q.4 rounding.
   localparam int ROUND_BIAS   = 2048;
   localparam int RESULT_SHIFT = 12;

   // Stream and register port widths.
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_A_RESET   = -16'sd4096;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_B_RESET   = 16'sd4096;
   localparam logic [NUM_W-1:0]           NUM_POINTS_RESET = 8'd100;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_SHADE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_WEIGHT_A   = 2'd0,
      REG_WEIGHT_B   = 2'd1,
      REG_NUM_POINTS = 2'd2
   } csr_index_type;

   // A squared distance moving down the cell row.
   typedef struct packed {
      logic            valid;
      logic [SQ_W-1:0] dist_sq;
   } cand_type;

endpackage

`default_nettype wire

// ===== rtl/cnoise_cell.sv =====
// ----------------------------------------------------------------------------
// cnoise_cell
// One cell of the nearest-distance row: keeps the smaller of its held value
// and the incoming candidate, and hands the larger one to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cnoise_cell import cnoise_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            clear,
   input  cand_type        cand_in,
   output cand_type        cand_out,
   output logic [SQ_W-1:0] best
);

   logic [SQ_W-1:0] best_ff;
   cand_type        out_ff;
   logic            keep_in;

   // Strictly smaller replaces, so an equal distance moves on to the next cell.
   assign keep_in = cand_in.dist_sq < best_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         best_ff      <= '1;
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= cand_in.valid;
         if (cand_in.valid) begin
            if (keep_in) begin
               best_ff        <= cand_in.dist_sq;
               out_ff.dist_sq <= best_ff;
            end else begin
               out_ff.dist_sq <= cand_in.dist_sq;
            end
         end
      end
   end

   assign cand_out = out_ff;
   assign best     = best_ff;

endmodule

`default_nettype wire

// ===== rtl/cnoise_isqrt.sv =====
// ----------------------------------------------------------------------------
// cnoise_isqrt
// Bit-serial floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cnoise_isqrt import cnoise_pkg::*; #(
   parameter int IN_W  = SQ_W,
   parameter int OUT_W = ROOT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IN_W-1:0]  value,
   output logic [OUT_W-1:0] root,
   output logic             done
);

   localparam int REM_W  = OUT_W + 3;
   localparam int STEP_W = (OUT_W > 1) ? $clog2(OUT_W) : 1;

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [IN_W-1:0]   val_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [OUT_W-1:0]  root_ff;

   logic [REM_W-1:0]  rem_pre;
   logic [REM_W-1:0]  trial;
   logic              fit;
   logic [REM_W-1:0]  rem_in;
   logic [OUT_W-1:0]  root_in;

   // Bring down the next two bits and try to append a one to the root.
   always_comb begin
      rem_pre = {rem_ff[REM_W-3:0], val_ff[IN_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      fit     = rem_pre >= trial;
      rem_in  = fit ? (rem_pre - trial) : rem_pre;
      root_in = {root_ff[OUT_W-2:0], fit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            val_ff  <= val_ff << 2;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(OUT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/cellular_noise_f2_minus_f1.sv =====
// ----------------------------------------------------------------------------
// cellular_noise_f2_minus_f1
// Worley cellular noise shader: height = weight_b * F2 + weight_a * F1.
// ----------------------------------------------------------------------------
// A point load request gives no response.
// A shade request gives its response once the scan of n entries, where n is
// num_points clamped to 2 .. MAX_POINTS, and the square roots are done. The
// response is parked once any earlier response has left the output register;
// the next request is then taken. The scan reads the point memory one entry
// per cycle, and the square root is bit-serial.
// Reset is synchronous and active high; requests are refused while it is high
// and the point memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cellular_noise_f2_minus_f1 import cnoise_pkg::*; #(
   parameter int MAX_POINTS     = MAX_POINTS_DEF,
   parameter int COORD_INT_BITS = COORD_INT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   // Requests. tuser: op. tdata, from bit 0 up: point_slot[6:0],
   // point_x[15:0], point_y[15:0], pixel_x[11:0], pixel_y[11:0], one zero bit.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,

   // Responses. tdata, from bit 0 up: height[21:0], two zero bits.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Sizing that follows from the parameters.
   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = (ADDR_W + 1 > NUM_W) ? ADDR_W + 1 : NUM_W;
   localparam int PT_W   = COORD_INT_BITS + FRAC_W;
   localparam int WORD_W = 2 * COORD_W;
   localparam int SQP_W  = 2 * COORD_W;

   // Coordinate bits above the configured format are dropped.
   localparam logic [COORD_W-1:0] PT_MASK =
      (PT_W >= COORD_W) ? '1 : COORD_W'((64'd1 << PT_W) - 64'd1);
   localparam logic [PIX_W-1:0] PIX_MASK =
      (COORD_INT_BITS >= PIX_W) ? '1 : PIX_W'((64'd1 << COORD_INT_BITS) - 64'd1);

   // Request field positions inside tdata.
   localparam int SLOT_LSB = 0;
   localparam int PTX_LSB  = SLOT_LSB + SLOT_W;
   localparam int PTY_LSB  = PTX_LSB + COORD_W;
   localparam int PXX_LSB  = PTY_LSB + COORD_W;
   localparam int PXY_LSB  = PXX_LSB + PIX_W;

   localparam logic signed [SUM_W-1:0] H_MAX = SUM_W'((64'sd1 <<< (HEIGHT_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] H_MIN = -H_MAX - SUM_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT,
      ST_MUL,
      ST_FIN
   } state_type;

   // ------------------------------------------------------------------------
   // Register port. pready is tied high, so a write lands at the access cycle.
   // ------------------------------------------------------------------------
   logic signed [WEIGHT_W-1:0] weight_a_ff;
   logic signed [WEIGHT_W-1:0] weight_b_ff;
   logic [NUM_W-1:0]           num_points_ff;
   csr_index_type              csr_index;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_a_ff   <= WEIGHT_A_RESET;
         weight_b_ff   <= WEIGHT_B_RESET;
         num_points_ff <= NUM_POINTS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WEIGHT_A:   weight_a_ff   <= csr_pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_B:   weight_b_ff   <= csr_pwdata[WEIGHT_W-1:0];
            REG_NUM_POINTS: num_points_ff <= csr_pwdata[NUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WEIGHT_A:   csr_prdata = CSR_DATA_W'($unsigned(weight_a_ff));
         REG_WEIGHT_B:   csr_prdata = CSR_DATA_W'($unsigned(weight_b_ff));
         REG_NUM_POINTS: csr_prdata = CSR_DATA_W'(num_points_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Request decode.
   // ------------------------------------------------------------------------
   state_type            state_ff;
   logic                 req_fire;
   op_type               req_op;
   logic [SLOT_W-1:0]    req_slot;
   logic [COORD_W-1:0]   req_point_x;
   logic [COORD_W-1:0]   req_point_y;
   logic [PIX_W-1:0]     req_pixel_x;
   logic [PIX_W-1:0]     req_pixel_y;
   logic                 slot_ok;
   logic                 load_fire;
   logic                 shade_fire;

   assign req_tready  = (state_ff == ST_IDLE) && !reset;
   assign req_fire    = req_tvalid && req_tready;
   assign req_op      = op_type'(req_tuser);
   assign req_slot    = req_tdata[SLOT_LSB +: SLOT_W];
   assign req_point_x = req_tdata[PTX_LSB +: COORD_W];
   assign req_point_y = req_tdata[PTY_LSB +: COORD_W];
   assign req_pixel_x = req_tdata[PXX_LSB +: PIX_W];
   assign req_pixel_y = req_tdata[PXY_LSB +: PIX_W];
   assign slot_ok     = CNT_W'(req_slot) < CNT_W'(MAX_POINTS);
   assign load_fire   = req_fire && (req_op == OP_LOAD) && slot_ok;
   assign shade_fire  = req_fire && (req_op == OP_SHADE);

   // Effective point count, clamped to 2 .. MAX_POINTS, and the last address
   // the scan visits.
   logic [CNT_W-1:0]  num_ext;
   logic [CNT_W-1:0]  num_eff;
   logic [ADDR_W-1:0] last_addr;

   always_comb begin
      num_ext = CNT_W'(num_points_ff);
      if (num_ext < CNT_W'(MIN_POINTS)) begin
         num_eff = CNT_W'(MIN_POINTS);
      end else if (num_ext > CNT_W'(MAX_POINTS)) begin
         num_eff = CNT_W'(MAX_POINTS);
      end else begin
         num_eff = num_ext;
      end
      last_addr = ADDR_W'(num_eff - CNT_W'(1));
   end

   // ------------------------------------------------------------------------
   // Point memory: one word per feature point, y in the upper half. Written by
   // load requests, read once per cycle during the scan.
   // ------------------------------------------------------------------------
   logic [WORD_W-1:0] point_mem [MAX_POINTS];
   logic [WORD_W-1:0] rd_word_ff;
   logic [ADDR_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (load_fire) begin
         point_mem[ADDR_W'(req_slot)] <= {req_point_y & PT_MASK, req_point_x & PT_MASK};
      end
      if (state_ff == ST_SCAN) begin
         rd_word_ff <= point_mem[addr_ff];
      end
   end

   // ------------------------------------------------------------------------
   // Distance pipeline: memory read, squares of the axis distances, their sum.
   // ------------------------------------------------------------------------
   logic [COORD_W-1:0] pix_x_ff;
   logic [COORD_W-1:0] pix_y_ff;
   logic               rd_v_ff;
   logic               sq_v_ff;
   logic               sum_v_ff;
   logic [SQP_W-1:0]   sqx_ff;
   logic [SQP_W-1:0]   sqy_ff;
   logic [SQ_W-1:0]    sum_ff;

   logic [COORD_W-1:0] rd_x;
   logic [COORD_W-1:0] rd_y;
   logic [COORD_W-1:0] dx_in;
   logic [COORD_W-1:0] dy_in;
   logic [SQP_W-1:0]   sqx_in;
   logic [SQP_W-1:0]   sqy_in;
   logic [SQ_W-1:0]    sum_in;

   always_comb begin
      rd_x   = rd_word_ff[COORD_W-1:0];
      rd_y   = rd_word_ff[WORD_W-1:COORD_W];
      dx_in  = (rd_x >= pix_x_ff) ? (rd_x - pix_x_ff) : (pix_x_ff - rd_x);
      dy_in  = (rd_y >= pix_y_ff) ? (rd_y - pix_y_ff) : (pix_y_ff - rd_y);
      sqx_in = SQP_W'(dx_in) * SQP_W'(dx_in);
      sqy_in = SQP_W'(dy_in) * SQP_W'(dy_in);
      sum_in = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         sq_v_ff  <= 1'b0;
         sum_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= (state_ff == ST_SCAN);
         sq_v_ff  <= rd_v_ff;
         sum_v_ff <= sq_v_ff;
      end
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sum_ff <= sum_in;
   end

   // ------------------------------------------------------------------------
   // Row of cells holding the nearest and second nearest squared distances.
   // Each candidate enters the first cell; a displaced or losing value moves
   // on to the next cell in the cycle after. A shade request clears the row.
   // ------------------------------------------------------------------------
   cand_type        cand_chain [NEAREST_KEPT+1];
   logic [SQ_W-1:0] best       [NEAREST_KEPT];
   logic            chain_busy;

   assign cand_chain[0] = '{valid: sum_v_ff, dist_sq: sum_ff};

   for (genvar k = 0; k < NEAREST_KEPT; k++) begin : g_cell
      cnoise_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (shade_fire),
         .cand_in  (cand_chain[k]),
         .cand_out (cand_chain[k+1]),
         .best     (best[k])
      );
   end

   always_comb begin
      chain_busy = 1'b0;
      for (int k = 1; k <= NEAREST_KEPT; k++) begin
         chain_busy = chain_busy | cand_chain[k].valid;
      end
   end

   // The row is settled once nothing is in flight in the pipeline or cells.
   logic drained;
   logic root_start;

   assign drained    = !rd_v_ff && !sq_v_ff && !sum_v_ff && !chain_busy;
   assign root_start = (state_ff == ST_DRAIN) && drained;

   // ------------------------------------------------------------------------
   // Square roots of the two kept distances, run side by side.
   // ------------------------------------------------------------------------
   logic [ROOT_W-1:0] root_d1;
   logic [ROOT_W-1:0] root_d2;
   logic              root_done_d1;
   logic              root_done_d2;

   cnoise_isqrt #(
      .IN_W  (SQ_W),
      .OUT_W (ROOT_W)
   ) u_isqrt_d1 (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (best[0]),
      .root  (root_d1),
      .done  (root_done_d1)
   );

   cnoise_isqrt #(
      .IN_W  (SQ_W),
      .OUT_W (ROOT_W)
   ) u_isqrt_d2 (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (best[1]),
      .root  (root_d2),
      .done  (root_done_d2)
   );

   // ------------------------------------------------------------------------
   // Weighting. The products are registered; the sum is rounded to Q.4 with
   // ties toward plus infinity and saturated to the height range.
   // ------------------------------------------------------------------------
   logic signed [PROD_W-1:0] prod_a_ff;
   logic signed [PROD_W-1:0] prod_b_ff;
   logic signed [PROD_W-1:0] prod_a_in;
   logic signed [PROD_W-1:0] prod_b_in;
   logic signed [SUM_W-1:0]  blend;
   logic signed [SUM_W-1:0]  scaled;
   logic [HEIGHT_W-1:0]      height_in;

   always_comb begin
      prod_a_in = PROD_W'(weight_a_ff) * PROD_W'($signed({1'b0, root_d1}));
      prod_b_in = PROD_W'(weight_b_ff) * PROD_W'($signed({1'b0, root_d2}));
      blend     = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff) + SUM_W'(ROUND_BIAS);
      scaled    = blend >>> RESULT_SHIFT;
      if (scaled > H_MAX) begin
         height_in = H_MAX[HEIGHT_W-1:0];
      end else if (scaled < H_MIN) begin
         height_in = H_MIN[HEIGHT_W-1:0];
      end else begin
         height_in = scaled[HEIGHT_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer. A shade request walks the point memory, waits for the cell
   // row to settle, takes both roots, weights them and parks the response in
   // the output register. The output register frees the request side, so the
   // next request is taken while a response still waits.
   // ------------------------------------------------------------------------
   logic                rsp_valid_ff;
   logic [HEIGHT_W-1:0] rsp_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (shade_fire) begin
                  pix_x_ff <= {req_pixel_x & PIX_MASK, FRAC_W'(0)};
                  pix_y_ff <= {req_pixel_y & PIX_MASK, FRAC_W'(0)};
                  addr_ff  <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               addr_ff <= addr_ff + ADDR_W'(1);
               if (addr_ff == last_addr) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (drained) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_done_d1 && root_done_d2) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_a_ff <= prod_a_in;
               prod_b_ff <= prod_b_in;
               state_ff  <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_height_ff <= height_in;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_height_ff);

endmodule

`default_nettype wire
